>>> design/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Types and codes shared by the compacting slot list and its engine.
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int SLOTS_DEF = 16;

    // request modes
    localparam logic [1:0] MODE_DROP      = 2'd0;
    localparam logic [1:0] MODE_PICK_IDX  = 2'd1;
    localparam logic [1:0] MODE_PICK_TYPE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL_DROP = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        item_valid;
        logic [15:0] item_handle;
        logic [7:0]  item_type;
        logic [3:0]  slot_index;
        logic [7:0]  type_key;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        got_item;
        logic [15:0] out_handle;
        logic [7:0]  out_type;
        logic [3:0]  out_index;
        logic        evicted;
        logic [15:0] evicted_handle;
        logic [4:0]  fill_now;
        logic        is_empty;
    } out_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  kind;
    } entry_t;

endpackage

>>> design/compacting_slot_list.sv
// ----------------------------------------------------------------------------
// compacting_slot_list
// Ordered list of handle/type entries with oldest eviction and gap closing.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carries one request beat (drop, pick by index,
//   pick by type). m_valid/m_ready/m_data returns exactly one result beat per
//   request, in order. One request is in flight at a time: s_ready drops on
//   accept and returns when the result is loaded into the output register.
//   A drop into a list with room, a rejected request or an unused mode goes
//   from decode straight to the result. A removal by index or by type, and
//   the eviction of slot 0 on a full drop, find the entry and close the gap
//   by moving each later entry down; a type search that misses scans the
//   whole list. The scan and compaction run through the slot memory, with a
//   single read and a single write port, moving one entry per cycle.
//   The output register frees s_ready only when it can take the result, so a
//   stalled receiver holds the block after the current request; the next
//   request is accepted while the held result waits to be taken.
//   Reset empties the list (fill count zero); slot contents are not cleared.
// ----------------------------------------------------------------------------
module compacting_slot_list #(
    parameter int SLOTS = csl_pkg::SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  csl_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output csl_pkg::out_t m_data
);

    logic          busy_reg, busy_next;
    logic          m_valid_reg, m_valid_next;
    csl_pkg::out_t m_data_reg;
    logic          accept;
    logic          res_valid;
    logic          res_ready;
    csl_pkg::out_t res;

    assign s_ready   = !busy_reg;
    assign accept    = s_valid && s_ready;
    assign res_ready = !m_valid_reg || m_ready;

    csl_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .req       (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            busy_next    = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/csl_engine.sv
// ----------------------------------------------------------------------------
// csl_engine
// Slot storage and the sequencer that appends, scans and compacts it, one
// slot per cycle through a single read and a single write port.
// ----------------------------------------------------------------------------
module csl_engine #(
    parameter int SLOTS = csl_pkg::SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  csl_pkg::in_t  req,
    output logic          res_valid,
    input  logic          res_ready,
    output csl_pkg::out_t res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    csl_pkg::in_t     req_reg, req_next;
    csl_pkg::out_t    res_reg, res_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             take_any_reg, take_any_next;
    logic             evict_reg, evict_next;

    csl_pkg::entry_t  mem [SLOTS];
    csl_pkg::entry_t  rd_data_reg;

    logic             we;
    logic [IDX_W-1:0] wr_addr;
    csl_pkg::entry_t  wr_data;
    logic             issue;
    logic             match;
    logic [CNT_W-1:0] pos_cnt;
    logic [IDX_W-1:0] pos;
    logic [IDX_W+3:0] pos_ext;
    logic [CNT_W+3:0] idx_ext;
    logic [CNT_W+3:0] fill_ext;
    logic [CNT_W+4:0] fill_out_ext;
    logic [CNT_W-1:0] fill_dec;

    // read issue runs ahead of the write pointer to cover the registered read
    assign issue   = (state_reg == S_SCAN || state_reg == S_SHIFT) && (ptr_reg < fill_reg);
    assign match   = rd_vld_reg && (take_any_reg || rd_data_reg.kind == req_reg.type_key);
    assign pos_cnt = ptr_reg - CNT_W'(1);
    assign pos     = pos_cnt[IDX_W-1:0];
    assign pos_ext = {4'b0, pos};
    assign idx_ext = {{CNT_W{1'b0}}, req_reg.slot_index};
    assign fill_ext = {4'b0, fill_reg};
    assign fill_out_ext = {5'b0, fill_reg};
    assign fill_dec = fill_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_vld_next   = rd_vld_reg;
        take_any_next = take_any_reg;
        evict_next    = evict_reg;
        we            = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                rd_vld_next   = 1'b0;
                take_any_next = 1'b0;
                evict_next    = 1'b0;
                ptr_next      = '0;
                case (req_reg.mode)
                    csl_pkg::MODE_DROP: begin
                        if (!req_reg.item_valid) begin
                            res_next.status = csl_pkg::ST_NULL_DROP;
                            state_next      = S_DONE;
                        end else if (fill_reg == CNT_W'(SLOTS)) begin
                            // full: pull out slot 0 and compact, append at the end
                            evict_next    = 1'b1;
                            take_any_next = 1'b1;
                            state_next    = S_SCAN;
                        end else begin
                            we         = 1'b1;
                            wr_addr    = fill_reg[IDX_W-1:0];
                            wr_data    = {req_reg.item_handle, req_reg.item_type};
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_DONE;
                        end
                    end
                    csl_pkg::MODE_PICK_IDX: begin
                        if (idx_ext < fill_ext) begin
                            ptr_next      = idx_ext[CNT_W-1:0];
                            take_any_next = 1'b1;
                            state_next    = S_SCAN;
                        end else begin
                            res_next.status = csl_pkg::ST_BAD_INDEX;
                            state_next      = S_DONE;
                        end
                    end
                    csl_pkg::MODE_PICK_TYPE: begin
                        if (fill_reg == '0) begin
                            res_next.status = csl_pkg::ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (issue) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                rd_vld_next = issue;
                if (match) begin
                    // read of pos+1 already issued this cycle feeds the shift
                    wr_ptr_next = pos;
                    if (evict_reg) begin
                        res_next.evicted        = 1'b1;
                        res_next.evicted_handle = rd_data_reg.handle;
                    end else begin
                        res_next.got_item   = 1'b1;
                        res_next.out_handle = rd_data_reg.handle;
                        res_next.out_type   = rd_data_reg.kind;
                        res_next.out_index  = pos_ext[3:0];
                    end
                    state_next = S_SHIFT;
                end else if (ptr_reg == fill_reg) begin
                    res_next.status = csl_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_SHIFT: begin
                if (issue) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                rd_vld_next = issue;
                if (rd_vld_reg) begin
                    we          = 1'b1;
                    wr_addr     = wr_ptr_reg;
                    wr_data     = rd_data_reg;
                    wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                end else if (!issue) begin
                    if (evict_reg) begin
                        we      = 1'b1;
                        wr_addr = fill_dec[IDX_W-1:0];
                        wr_data = {req_reg.item_handle, req_reg.item_type};
                    end else begin
                        fill_next = fill_dec;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res          = res_reg;
        res.fill_now = fill_out_ext[4:0];
        res.is_empty = (fill_reg == '0);
    end

    assign res_valid = (state_reg == S_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            take_any_reg <= 1'b0;
            evict_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_vld_reg   <= rd_vld_next;
            take_any_reg <= take_any_next;
            evict_reg    <= evict_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        ptr_reg    <= ptr_next;
        wr_ptr_reg <= wr_ptr_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(SLOTS))
        else $error("fill count above slot capacity");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == S_IDLE)
        else $error("request started while engine busy");

    a_shift_below_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && rd_vld_reg) |-> ({1'b0, wr_ptr_reg} < {1'b0, fill_reg}))
        else $error("compaction write at or above fill");

    a_done_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_ready) |=> state_reg == S_IDLE)
        else $error("result taken but engine not released");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(fill_reg))
        else $error("fill count moved while idle");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compacting_slot_list: a shadow copy of the ordered
// list predicts every result beat, and a scoreboard compares each beat field by
// field, in order. Directed requests cover empty, full and boundary cases, and
// random traffic alternates fill-heavy and drain-heavy bursts. Both sides of
// the block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS = csl_pkg::SLOTS_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 875;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AFTER_RESULTS = 300;
    localparam int HOLD_CYCLES = 400;

    class slot_list_scoreboard;
        csl_pkg::entry_t shadow [SLOTS];
        int shadow_fill;
        csl_pkg::out_t pending_results[$];
        int mismatches;
        int results_checked;

        function new();
            shadow_fill = 0;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void remove_at(int pos);
            for (int k = pos; k + 1 < shadow_fill; k++) begin
                shadow[k] = shadow[k + 1];
            end
            if (shadow_fill > 0) begin
                shadow_fill--;
            end
        endfunction

        // Update the shadow list with one accepted request and queue its result.
        function void note_request(csl_pkg::in_t req);
            csl_pkg::out_t res;
            int pos;
            bit take;
            res = '0;
            pos = 0;
            take = 0;
            case (req.mode)
                csl_pkg::MODE_DROP: begin
                    if (!req.item_valid) begin
                        res.status = csl_pkg::ST_NULL_DROP;
                    end else begin
                        if (shadow_fill == SLOTS) begin
                            res.evicted = 1'b1;
                            res.evicted_handle = shadow[0].handle;
                            remove_at(0);
                        end
                        shadow[shadow_fill].handle = req.item_handle;
                        shadow[shadow_fill].kind = req.item_type;
                        shadow_fill++;
                    end
                end
                csl_pkg::MODE_PICK_IDX: begin
                    if (int'(req.slot_index) < shadow_fill) begin
                        pos = int'(req.slot_index);
                        take = 1;
                    end else begin
                        res.status = csl_pkg::ST_BAD_INDEX;
                    end
                end
                csl_pkg::MODE_PICK_TYPE: begin
                    for (int k = 0; k < shadow_fill && !take; k++) begin
                        if (shadow[k].kind == req.type_key) begin
                            pos = k;
                            take = 1;
                        end
                    end
                    if (!take) begin
                        res.status = csl_pkg::ST_NOT_FOUND;
                    end
                end
                default: ;
            endcase
            if (take) begin
                res.got_item = 1'b1;
                res.out_handle = shadow[pos].handle;
                res.out_type = shadow[pos].kind;
                res.out_index = pos[3:0];
                remove_at(pos);
            end
            res.fill_now = shadow_fill[4:0];
            res.is_empty = (shadow_fill == 0);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(csl_pkg::out_t seen);
            csl_pkg::out_t want;
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding: %0h", seen);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(seen.status));
            compare_field("got_item", 32'(want.got_item), 32'(seen.got_item));
            compare_field("out_handle", 32'(want.out_handle), 32'(seen.out_handle));
            compare_field("out_type", 32'(want.out_type), 32'(seen.out_type));
            compare_field("out_index", 32'(want.out_index), 32'(seen.out_index));
            compare_field("evicted", 32'(want.evicted), 32'(seen.evicted));
            compare_field("evicted_handle", 32'(want.evicted_handle),
                          32'(seen.evicted_handle));
            compare_field("fill_now", 32'(want.fill_now), 32'(seen.fill_now));
            compare_field("is_empty", 32'(want.is_empty), 32'(seen.is_empty));
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    csl_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    csl_pkg::out_t m_data;

    slot_list_scoreboard sb;
    int unsigned cycle_count;

    compacting_slot_list #(.SLOTS(SLOTS)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        sb = new();
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial cycle_count = 0;

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Receiver: stall style is redrawn at random while the bench runs, plus one long hold-off
    // once enough results have gone by, so the block backs up into s_ready.
    initial begin
        int style;
        int hold_left;
        bit hold_done;
        style = 0;
        hold_left = 0;
        hold_done = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (cycle_count % 100 == 0) begin
                style = $urandom_range(0, 3);
            end
            if (!hold_done && sb.results_checked >= HOLD_AFTER_RESULTS) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (style)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 1) == 1);
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = ((cycle_count % 8) < 5);
                endcase
            end
        end
    end

    // Present one request beat and hold it until accepted.
    task automatic send_request(csl_pkg::in_t req);
        @(negedge aclk);
        s_valid = 1'b1;
        s_data = req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic idle_sender(int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic wait_drained();
        idle_sender(0);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic csl_pkg::in_t make_fields(logic [1:0] mode, logic valid,
                                                 logic [15:0] handle, logic [7:0] kind,
                                                 logic [3:0] index, logic [7:0] key);
        csl_pkg::in_t r;
        r.mode = mode;
        r.item_valid = valid;
        r.item_handle = handle;
        r.item_type = kind;
        r.slot_index = index;
        r.type_key = key;
        return r;
    endfunction

    // Random request steered by the shadow list so that picks mostly hit.
    function automatic csl_pkg::in_t random_request(bit fill_heavy);
        csl_pkg::in_t r;
        int unsigned roll;
        int unsigned drop_pct;
        r = make_fields(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        16'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        drop_pct = fill_heavy ? 70 : 30;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            r.mode = MODE_UNUSED;
        end else if (roll < 3 + drop_pct) begin
            r.mode = csl_pkg::MODE_DROP;
            r.item_valid = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 3) != 0) begin
                r.item_type = 8'($urandom_range(0, 7));
            end
        end else if (roll < 3 + drop_pct + (97 - drop_pct) / 2) begin
            r.mode = csl_pkg::MODE_PICK_IDX;
            if (sb.shadow_fill > 0 && $urandom_range(0, 6) != 0) begin
                r.slot_index = 4'($urandom_range(0, sb.shadow_fill - 1));
            end
        end else begin
            r.mode = csl_pkg::MODE_PICK_TYPE;
            if (sb.shadow_fill > 0 && $urandom_range(0, 9) < 7) begin
                r.type_key = sb.shadow[$urandom_range(0, sb.shadow_fill - 1)].kind;
            end else if ($urandom_range(0, 1) == 1) begin
                r.type_key = 8'($urandom_range(0, 7));
            end
        end
        return r;
    endfunction

    initial begin
        int sent;
        int burst;
        bit fill_heavy;
        bit paused;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty list, null drop, unused mode, fill, evict, boundaries
        send_request(make_fields(csl_pkg::MODE_PICK_IDX, 1'b1, 16'hFFFF, 8'hFF, 4'hF, 8'hFF));
        send_request(make_fields(csl_pkg::MODE_PICK_TYPE, 1'b0, 16'h0000, 8'h00, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_DROP, 1'b0, 16'hFFFF, 8'hFF, 4'hF, 8'hFF));
        send_request(make_fields(MODE_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 4'hF, 8'hFF));
        send_request(make_fields(csl_pkg::MODE_DROP, 1'b1, 16'h1234, 8'h5A, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_DROP, 1'b1, 16'hFFFF, 8'hFF, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_DROP, 1'b1, 16'h0000, 8'h00, 4'h0, 8'h00));
        for (int k = 3; k < SLOTS; k++) begin
            send_request(make_fields(csl_pkg::MODE_DROP, 1'b1, 16'(16'h0100 + k), 8'(k),
                                     4'h0, 8'h00));
        end
        send_request(make_fields(csl_pkg::MODE_DROP, 1'b1, 16'hABCD, 8'h5A, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_PICK_IDX, 1'b0, 16'h0000, 8'h00, 4'hF, 8'h00));
        send_request(make_fields(csl_pkg::MODE_PICK_IDX, 1'b0, 16'h0000, 8'h00, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_PICK_TYPE, 1'b0, 16'h0000, 8'h00, 4'h0, 8'h00));
        send_request(make_fields(csl_pkg::MODE_PICK_IDX, 1'b0, 16'h0000, 8'h00, 4'hE, 8'h00));

        wait_drained();

        sent = 0;
        paused = 0;
        fill_heavy = 1;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) begin
                fill_heavy = ~fill_heavy;
            end
            for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
                send_request(random_request(fill_heavy));
                sent++;
            end
            if (!paused && sent >= RANDOM_REQUESTS / 2) begin
                paused = 1;
                wait_drained();
            end else if ($urandom_range(0, 2) != 0) begin
                idle_sender($urandom_range(0, 10));
            end
        end

        wait_drained();
        repeat (SLOTS + 24) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/csl_pkg.sv
design/csl_engine.sv
design/compacting_slot_list.sv
verif/testbench.sv
